>>> hw/rtl/stfp_pkg.sv
// Shared types and constants for the sensor telemetry frame packer.
`default_nettype none

package stfp_pkg;

  // Frame marks and fill
  localparam logic [7:0] START_MARK = 8'hA0;
  localparam logic [7:0] STOP_MARK  = 8'h0A;
  localparam logic [7:0] FILL_BYTE  = 8'hFF;

  localparam int FRAME_LEN = 16;
  localparam int IDX_W     = 4;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  // Lane geometry
  localparam int NUM_LANES = 5;
  localparam int MAG_W     = 23;
  localparam int WHOLE_W   = 17;
  localparam int PROD_W    = 54;
  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for any 32-bit x
  localparam logic [30:0] RECIP_100   = 31'h51EB851F;
  localparam int          RECIP_SHIFT = 37;

  // Lane order in the frame
  localparam int LANE_TEMP = 0;
  localparam int LANE_PH   = 1;
  localparam int LANE_TDS  = 2;
  localparam int LANE_COND = 3;
  localparam int LANE_OXY  = 4;

  typedef struct packed {
    logic signed [15:0] temperature_centi;
    logic               temperature_ok;
    logic [14:0]        ph_centi;
    logic               ph_ok;
    logic [22:0]        tds_centi;
    logic               tds_ok;
    logic [22:0]        cond_centi;
    logic               cond_ok;
    logic [22:0]        oxy_centi;
    logic               oxy_ok;
  } reading_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } beat_t;

  // Bytes one lane contributes (fill already applied)
  typedef struct packed {
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] fr;
  } lane_bytes_t;

  // Pipeline load enables from the top-level control
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic load_m;
  } pipe_ctl_t;

  typedef logic [FRAME_LEN-1:0][7:0] frame_t;

endpackage

`default_nettype wire

>>> hw/rtl/stfp_lane.sv
// One conversion lane: splits a magnitude in hundredths into integer and decimal bytes.
`default_nettype none

module stfp_lane (
  input  wire logic                     clk,
  input  wire stfp_pkg::pipe_ctl_t      ctl,
  input  wire logic [stfp_pkg::MAG_W-1:0] mag,
  input  wire logic                     ok,
  output stfp_pkg::lane_bytes_t         bytes
);
  import stfp_pkg::*;

  logic [MAG_W-1:0]   mag_a;
  logic               ok_a;
  logic [PROD_W-1:0]  prod_a;
  logic [WHOLE_W-1:0] whole;
  logic [23:0]        whole_x100;
  logic [MAG_W-1:0]   frac_full;
  lane_bytes_t        bytes_next;

  // Stage A: multiply by the reciprocal of 100
  always_ff @(posedge clk) begin
    if (ctl.load_a) begin
      mag_a  <= mag;
      ok_a   <= ok;
      prod_a <= PROD_W'(mag) * PROD_W'(RECIP_100);
    end
  end

  // Recover quotient and remainder
  always_comb begin
    whole      = prod_a[RECIP_SHIFT +: WHOLE_W];
    whole_x100 = 24'(whole) * 24'd100;
    frac_full  = mag_a - whole_x100[MAG_W-1:0];
    if (ok_a) begin
      bytes_next.hi = whole[15:8];
      bytes_next.lo = whole[7:0];
      bytes_next.fr = {1'b0, frac_full[6:0]};
    end else begin
      bytes_next.hi = FILL_BYTE;
      bytes_next.lo = FILL_BYTE;
      bytes_next.fr = FILL_BYTE;
    end
  end

  // Stage B: hold the lane bytes
  always_ff @(posedge clk) begin
    if (ctl.load_b) begin
      bytes <= bytes_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/stfp_merge.sv
// Merge stage: assembles the lane bytes into a 16-byte frame with checksum.
`default_nettype none

module stfp_merge (
  input  wire logic                 clk,
  input  wire stfp_pkg::pipe_ctl_t  ctl,
  input  wire stfp_pkg::lane_bytes_t lanes [stfp_pkg::NUM_LANES],
  output stfp_pkg::frame_t          frame
);
  import stfp_pkg::*;

  frame_t     frame_next;
  logic [7:0] sum_lo;
  logic [7:0] sum_hi;

  // Lay out the payload bytes and fold them into the checksum
  always_comb begin
    frame_next[0]  = START_MARK;
    frame_next[1]  = lanes[LANE_TEMP].lo;
    frame_next[2]  = lanes[LANE_TEMP].fr;
    frame_next[3]  = lanes[LANE_PH].lo;
    frame_next[4]  = lanes[LANE_PH].fr;
    frame_next[5]  = lanes[LANE_TDS].hi;
    frame_next[6]  = lanes[LANE_TDS].lo;
    frame_next[7]  = lanes[LANE_TDS].fr;
    frame_next[8]  = lanes[LANE_COND].hi;
    frame_next[9]  = lanes[LANE_COND].lo;
    frame_next[10] = lanes[LANE_COND].fr;
    frame_next[11] = lanes[LANE_OXY].hi;
    frame_next[12] = lanes[LANE_OXY].lo;
    frame_next[13] = lanes[LANE_OXY].fr;
    sum_lo = (frame_next[1] + frame_next[2]) + (frame_next[3] + frame_next[4])
           + (frame_next[5] + frame_next[6]) + frame_next[7];
    sum_hi = (frame_next[8] + frame_next[9]) + (frame_next[10] + frame_next[11])
           + (frame_next[12] + frame_next[13]);
    frame_next[14] = sum_lo + sum_hi;
    frame_next[15] = STOP_MARK;
  end

  // Hold the finished frame
  always_ff @(posedge clk) begin
    if (ctl.load_m) begin
      frame <= frame_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sensor_telemetry_frame_packer_top.sv
// Sensor telemetry frame packer: five conversion lanes, merge stage and byte serializer.
//
// Usage:
//   The readings channel (reading_valid / reading_stall / readings) takes one set
//   of five sensor readings per beat. The frame channel (frame_valid /
//   frame_stall / frame_beat) returns 16 beats per set: 0xA0, the reading bytes,
//   a checksum byte and 0x0A, the last flagged by last_byte.
//   Each set passes the lane multiply, lane split, merge and serializer load
//   stages before its first frame beat is shown.
//   Throughput: one frame beat per cycle while frame_stall is low; the
//   serializer's 16 bytes per frame limit the set rate. Up to three further
//   sets are taken and held in the lane and merge stages while a frame drains.
//   Reset clears all stage valids and the serializer; no beat is shown until a
//   set is accepted. When the receiver stalls, the current beat holds, the
//   stages behind it fill, and reading_stall rises once all are full.
`default_nettype none

module sensor_telemetry_frame_packer_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               reading_valid,
  output logic                    reading_stall,
  input  wire stfp_pkg::reading_t readings,
  output logic                    frame_valid,
  input  wire logic               frame_stall,
  output stfp_pkg::beat_t         frame_beat
);
  import stfp_pkg::*;

  logic                 v_a;
  logic                 v_b;
  logic                 v_m;
  logic                 adv_a;
  logic                 adv_b;
  logic                 adv_m;
  logic                 accept;
  logic                 beat_done;
  logic                 last_done;
  logic                 load_ser;
  pipe_ctl_t            ctl;
  logic [MAG_W-1:0]     mags [NUM_LANES];
  logic                 oks  [NUM_LANES];
  lane_bytes_t          lane_out [NUM_LANES];
  logic [16:0]          temp_mag;
  frame_t               merged;
  frame_t               frame_q;
  logic [IDX_W-1:0]     idx;

  // Serializer handshake
  assign beat_done = frame_valid && !frame_stall;
  assign last_done = beat_done && (idx == LAST_IDX);
  assign load_ser  = v_m && (!frame_valid || last_done);

  // Stage advance, back to front
  assign adv_m  = !v_m || load_ser;
  assign adv_b  = !v_b || adv_m;
  assign adv_a  = !v_a || adv_b;
  assign accept = reading_valid && adv_a;
  assign reading_stall = !adv_a;

  assign ctl.load_a = accept;
  assign ctl.load_b = adv_b && v_a;
  assign ctl.load_m = adv_m && v_b;

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v_a <= 1'b0;
      v_b <= 1'b0;
      v_m <= 1'b0;
    end else begin
      if (adv_a) v_a <= accept;
      if (adv_b) v_b <= v_a;
      if (adv_m) v_m <= v_b;
    end
  end

  // Take the temperature magnitude, most negative value included
  always_comb begin
    if (readings.temperature_centi[15]) begin
      temp_mag = 17'h10000 - {1'b0, readings.temperature_centi};
    end else begin
      temp_mag = {1'b0, readings.temperature_centi};
    end
    mags[LANE_TEMP] = MAG_W'(temp_mag);
    mags[LANE_PH]   = MAG_W'(readings.ph_centi);
    mags[LANE_TDS]  = readings.tds_centi;
    mags[LANE_COND] = readings.cond_centi;
    mags[LANE_OXY]  = readings.oxy_centi;
    oks[LANE_TEMP]  = readings.temperature_ok;
    oks[LANE_PH]    = readings.ph_ok;
    oks[LANE_TDS]   = readings.tds_ok;
    oks[LANE_COND]  = readings.cond_ok;
    oks[LANE_OXY]   = readings.oxy_ok;
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    stfp_lane u_lane (
      .clk   (clk),
      .ctl   (ctl),
      .mag   (mags[g]),
      .ok    (oks[g]),
      .bytes (lane_out[g])
    );
  end

  stfp_merge u_merge (
    .clk   (clk),
    .ctl   (ctl),
    .lanes (lane_out),
    .frame (merged)
  );

  // Serializer control: load a frame, step one beat per accepted handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
      idx         <= '0;
    end else begin
      if (load_ser) begin
        frame_valid <= 1'b1;
        idx         <= '0;
      end else if (last_done) begin
        frame_valid <= 1'b0;
      end else if (beat_done) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // Hold the frame being sent
  always_ff @(posedge clk) begin
    if (load_ser) begin
      frame_q <= merged;
    end
  end

  assign frame_beat.frame_byte = frame_q[idx];
  assign frame_beat.last_byte  = (idx == LAST_IDX);

endmodule

`default_nettype wire

>>> hw/rtl/stfp_checker.sv
// Port-level checks on the frame packer output stream, bound to the top level.
`default_nettype none

module stfp_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               frame_valid,
  input wire logic               frame_stall,
  input wire stfp_pkg::beat_t    frame_beat
);
  import stfp_pkg::*;

  // No beat right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !frame_valid)
    else $error("frame beat shown right after reset");

  // A stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_stall |=> frame_valid && $stable(frame_beat))
    else $error("stalled frame beat changed");

  // A frame streams without gaps until its last beat
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_stall && !frame_beat.last_byte |=> frame_valid)
    else $error("gap inside a frame");

  // The last beat carries the stop mark
  a_stop: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_beat.last_byte |-> frame_beat.frame_byte == STOP_MARK)
    else $error("last beat is not the stop mark");

  // A beat after a finished frame opens with the start mark
  a_start: assert property (@(posedge clk) disable iff (rst)
    frame_valid && !frame_stall && frame_beat.last_byte
      |=> !frame_valid || frame_beat.frame_byte == START_MARK)
    else $error("frame does not open with the start mark");

endmodule

bind sensor_telemetry_frame_packer_top stfp_checker u_stfp_checker (.*);

`default_nettype wire
